FILE: rtl/core/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared constants, codes and helpers of the voxel face culler.
// ----------------------------------------------------------------------------
package vfc_pkg;

	// Grid geometry.
	localparam int EDGE   = 16;
	localparam int CW     = 4;
	localparam int PLANE  = EDGE * EDGE;
	localparam int CELLS  = EDGE * EDGE * EDGE;
	localparam int ADDR_W = $clog2(CELLS);

	// Item function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Face direction codes.
	localparam logic [2:0] DIR_PX = 3'd0;
	localparam logic [2:0] DIR_NX = 3'd1;
	localparam logic [2:0] DIR_PY = 3'd2;
	localparam logic [2:0] DIR_NY = 3'd3;
	localparam logic [2:0] DIR_PZ = 3'd4;
	localparam logic [2:0] DIR_NZ = 3'd5;
	localparam int NUM_DIRS = 6;

	// Configuration register indexes.
	localparam logic [2:0] REG_AIR_CODE = 3'd0;
	localparam logic [2:0] REG_BASE_X   = 3'd1;
	localparam logic [2:0] REG_BASE_Y   = 3'd2;
	localparam logic [2:0] REG_BASE_Z   = 3'd3;
	localparam logic [2:0] REG_PITCH    = 3'd4;

	localparam logic [31:0] PITCH_RESET = 32'h0001_0000;

	typedef logic [CW-1:0]     coord_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Linear cell address, x major and z minor.
	function automatic addr_t cell_addr(input coord_t x, input coord_t y, input coord_t z);
		logic [ADDR_W+CW-1:0] a;
		begin
			a = (ADDR_W+CW)'(x) * (ADDR_W+CW)'(PLANE) + (ADDR_W+CW)'(y) * (ADDR_W+CW)'(EDGE)
				+ (ADDR_W+CW)'(z);
			return a[ADDR_W-1:0];
		end
	endfunction

	// Signed base plus unsigned product, clamped to the signed 32-bit range.
	function automatic logic [31:0] sat_origin(input logic [31:0] base,
			input logic [CW+31:0] prod);
		logic signed [CW+33:0] sum;
		begin
			sum = $signed({{(CW+2){base[31]}}, base}) + $signed({2'b00, prod});
			if (sum > $signed((CW+34)'(32'h7FFF_FFFF))) begin
				return 32'h7FFF_FFFF;
			end else if (sum < -$signed((CW+34)'(33'h0_8000_0000))) begin
				return 32'h8000_0000;
			end else begin
				return sum[31:0];
			end
		end
	endfunction

endpackage

FILE: rtl/core/vfc_ram.sv
// ----------------------------------------------------------------------------
// vfc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vfc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/voxel_face_culler.sv
// ----------------------------------------------------------------------------
// voxel_face_culler
// Hidden-face culling over a cubic grid of voxel solid flags held in one RAM.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   func, coord_x/y/z, material
//  face      out        face_valid / face_stall   face_x/y/z, face_dir, origin_x/y/z, last_face
//  cfg       in         cfg_we                    cfg_idx, cfg_wdata
//
// A write item leaves the item side free. A query stalls the item side after
// acceptance while the single read port of the flag RAM reads the center and its six
// neighbors, then while the visible faces leave in turn, longer while the face side stalls.
// After reset a clearing pass marks all 4096 voxels solid, one per cycle; items are
// stalled meanwhile, configuration writes are taken as ever.
// The face register holds a result under stall while the next item is accepted.
// ----------------------------------------------------------------------------
module voxel_face_culler
	import vfc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               func,
	input  logic [3:0]         coord_x,
	input  logic [3:0]         coord_y,
	input  logic [3:0]         coord_z,
	input  logic [7:0]         material,
	output logic               face_valid,
	input  logic               face_stall,
	output logic [3:0]         face_x,
	output logic [3:0]         face_y,
	output logic [3:0]         face_z,
	output logic [2:0]         face_dir,
	output logic signed [31:0] origin_x,
	output logic signed [31:0] origin_y,
	output logic signed [31:0] origin_z,
	output logic               last_face,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [2:0] SCAN_LAST = 3'd7;

	logic [1:0]          state_q;
	addr_t               clr_q;
	logic [2:0]          cnt_q;
	logic                solid_q;
	logic [NUM_DIRS-1:0] mask_q;
	coord_t              x_q, y_q, z_q;

	logic [7:0]  air_code_q;
	logic [31:0] base_x_q, base_y_q, base_z_q, pitch_q;

	logic [CW+31:0] prod_x_q, prod_y_q, prod_z_q;
	logic [31:0]    org_x_q, org_y_q, org_z_q;

	logic  item_acc, in_range;
	logic  ram_we, ram_wdata, ram_rdata;
	addr_t ram_waddr, ram_raddr;

	logic [2:0]          iss_dir, ret_dir;
	coord_t              nx, ny, nz;
	logic                nb_out, nb_out_s1;
	logic [NUM_DIRS-1:0] mask_nxt;

	logic [2:0]          sel;
	logic                sel_found;
	logic [NUM_DIRS-1:0] mask_rest;
	logic                face_load;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign in_range   = (int'(coord_x) < EDGE) && (int'(coord_y) < EDGE)
		&& (int'(coord_z) < EDGE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_code_q <= '0;
			base_x_q   <= '0;
			base_y_q   <= '0;
			base_z_q   <= '0;
			pitch_q    <= PITCH_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_AIR_CODE: air_code_q <= cfg_wdata[7:0];
				REG_BASE_X:   base_x_q   <= cfg_wdata;
				REG_BASE_Y:   base_y_q   <= cfg_wdata;
				REG_BASE_Z:   base_z_q   <= cfg_wdata;
				REG_PITCH:    pitch_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Origins pass through a product register and then an origin register after the
	// coordinates are latched, well before the first face can leave.
	always_ff @(posedge clk) begin
		prod_x_q <= (CW+32)'(x_q) * (CW+32)'(pitch_q);
		prod_y_q <= (CW+32)'(y_q) * (CW+32)'(pitch_q);
		prod_z_q <= (CW+32)'(z_q) * (CW+32)'(pitch_q);
		org_x_q  <= sat_origin(base_x_q, prod_x_q);
		org_y_q  <= sat_origin(base_y_q, prod_y_q);
		org_z_q  <= sat_origin(base_z_q, prod_z_q);
	end

	// Read address of the current scan step. Step zero reads the voxel itself.
	always_comb begin
		iss_dir = cnt_q - 3'd1;
		nx      = x_q;
		ny      = y_q;
		nz      = z_q;
		nb_out  = 1'b0;
		case (iss_dir)
			DIR_PX: begin
				nx     = x_q + CW'(1);
				nb_out = (x_q == CW'(EDGE - 1));
			end
			DIR_NX: begin
				nx     = x_q - CW'(1);
				nb_out = (x_q == '0);
			end
			DIR_PY: begin
				ny     = y_q + CW'(1);
				nb_out = (y_q == CW'(EDGE - 1));
			end
			DIR_NY: begin
				ny     = y_q - CW'(1);
				nb_out = (y_q == '0);
			end
			DIR_PZ: begin
				nz     = z_q + CW'(1);
				nb_out = (z_q == CW'(EDGE - 1));
			end
			DIR_NZ: begin
				nz     = z_q - CW'(1);
				nb_out = (z_q == '0);
			end
			default: ;
		endcase
	end

	assign ram_raddr = cell_addr(nx, ny, nz);

	always_ff @(posedge clk) begin
		nb_out_s1 <= nb_out;
	end

	// Writes only land while items are accepted or during the clearing pass, and
	// the item side is stalled across every query scan, so no read can overlap a
	// write to the same cell.
	assign ram_we    = (state_q == ST_CLEAR) || (item_acc && in_range && func == FUNC_WRITE);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : cell_addr(coord_x, coord_y, coord_z);
	assign ram_wdata = (state_q == ST_CLEAR) ? 1'b1 : (material != air_code_q);

	vfc_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_flags (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// A neighbor read returns through the registered RAM read data; an out-of-grid or air neighbor marks a face.
	always_comb begin
		ret_dir  = cnt_q - 3'd2;
		mask_nxt = mask_q;
		if (cnt_q >= 3'd2) begin
			mask_nxt[ret_dir] = nb_out_s1 || !ram_rdata;
		end
	end

	// Lowest pending direction goes out first.
	always_comb begin
		sel       = '0;
		sel_found = 1'b0;
		for (int i = 0; i < NUM_DIRS; i++) begin
			if (mask_q[i] && !sel_found) begin
				sel       = 3'(i);
				sel_found = 1'b1;
			end
		end
		mask_rest      = mask_q;
		mask_rest[sel] = 1'b0;
	end

	assign face_load = (state_q == ST_EMIT) && (!face_valid || !face_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_acc && in_range && func == FUNC_QUERY) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == SCAN_LAST) begin
						state_q <= (solid_q && mask_nxt != '0) ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (face_load && mask_rest == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			x_q    <= coord_x;
			y_q    <= coord_y;
			z_q    <= coord_z;
			mask_q <= '0;
		end else if (state_q == ST_SCAN) begin
			mask_q <= mask_nxt;
			if (cnt_q == 3'd1) begin
				solid_q <= ram_rdata;
			end
		end else if (face_load) begin
			mask_q <= mask_rest;
		end
	end

	// Face output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_valid <= 1'b0;
		end else if (face_load) begin
			face_valid <= 1'b1;
		end else if (!face_stall) begin
			face_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (face_load) begin
			face_x    <= x_q;
			face_y    <= y_q;
			face_z    <= z_q;
			face_dir  <= sel;
			origin_x  <= org_x_q;
			origin_y  <= org_y_q;
			origin_z  <= org_z_q;
			last_face <= (mask_rest == '0);
		end
	end

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_EMIT) |-> !ram_we)
		else $error("flag RAM written during a query");

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> item_stall)
		else $error("item accepted during the clearing pass");

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (mask_q != '0))
		else $error("emitting with no visible face pending");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(face_load && mask_rest == '0) |=> (state_q == ST_IDLE && face_valid && last_face))
		else $error("last face did not end the query");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid |-> (face_dir <= DIR_NZ))
		else $error("face direction out of range");

endmodule
